### sv/wsgd_pkg.sv
// Package with constants and codes shared by the wheel speed and gear detector.
`timescale 1ns / 1ps
`default_nettype none

package wsgd_pkg;

    // Timing limits in microseconds.
    localparam logic [31:0] MIN_GAP_US = 32'd200;
    localparam logic [31:0] TIMEOUT_US = 32'd100000;

    // Number of gear ratios that are searched, from first gear upwards.
    localparam int GEARS_USED = 6;
    localparam int GEAR_SLOTS = 6;

    // Speed is SPEED_SCALE divided by period times pulse constant.
    localparam int DIV_W = 27;
    localparam logic [DIV_W-1:0] SPEED_SCALE = 27'd100000000;
    localparam logic [15:0] SPEED_MAX = 16'hFFFF;

    // Gear search is skipped below these limits.
    localparam logic [15:0] LOW_SPEED_LIMIT = 16'd3;
    localparam logic [15:0] LOW_RPM_LIMIT   = 16'd800;
    localparam logic [6:0]  PCT_SCALE       = 7'd100;

    // Item operation codes.
    localparam logic OP_PULSE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_PPM   = 3'd0;
    localparam logic [2:0] REG_TOL   = 3'd1;
    localparam logic [2:0] REG_GEAR1 = 3'd2;

    // Configuration reset values.
    localparam logic [15:0] PPM_RESET = 16'd1665;
    localparam logic [6:0]  TOL_RESET = 7'd10;

    typedef logic [15:0] t_ratio_tab [GEAR_SLOTS];
    localparam t_ratio_tab GEAR_RESET = '{16'd3213, 16'd2334, 16'd2002,
                                          16'd1698, 16'd1518, 16'd1405};

endpackage

`default_nettype wire

### sv/wheel_speed_and_gear_detector.sv
// Top level of the wheel speed and gear detector with its sequencer and shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                  | Words
// ----------+-----------+----------------------------+------------------------------------
// input     | in        | i_in_valid / o_in_stall    | operation, now_us, rpm, clutch
// result    | out       | o_out_valid / i_out_stall  | speed, gear_number
// config    | in        | i_cfg_we                   | i_cfg_index, i_cfg_wdata
//
// A pulse word is taken without a stall and gives no result. An evaluate word stalls the
// input until its result is loaded: straight to the load when no speed is measured, else
// a multiply, 27 divide steps, a gear check, the WANT, TOL and HUND steps for each gear
// tried (at most 6) and the load; the bit-serial divider and the shared 32x16 multiplier set this.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result register holds its word and the finished evaluation waits for it.

module wheel_speed_and_gear_detector
    import wsgd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_operation,
    input  wire logic [31:0] i_now_us,
    input  wire logic [15:0] i_engine_rpm,
    input  wire logic        i_clutch_pressed,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_speed,
    output logic [2:0]       o_gear_number,
    // Configuration port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_GSEL = 3'd3;
    localparam logic [2:0] S_WANT = 3'd4;
    localparam logic [2:0] S_TOL  = 3'd5;
    localparam logic [2:0] S_HUND = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam logic [4:0] DIV_LAST  = 5'(DIV_W - 1);
    localparam logic [2:0] GEAR_LAST = 3'(GEARS_USED - 1);

    // Control registers.
    logic [2:0]  r_state;
    logic        r_out_valid;
    logic [31:0] r_last_time;
    logic [31:0] r_period;
    logic        r_fresh;
    logic [15:0] r_ppm;
    logic [6:0]  r_tol;
    logic [15:0] r_ratio [GEAR_SLOTS];
    logic [4:0]  r_cnt;
    logic [2:0]  r_g;

    // Working and payload registers.
    logic [15:0]      r_rpm;
    logic             r_clutch;
    logic [47:0]      r_den;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [15:0]      r_speed;
    logic [31:0]      r_want;
    logic [31:0]      r_diff;
    logic [38:0]      r_tolw;
    logic [2:0]       r_gear;
    logic [15:0]      r_out_speed;
    logic [2:0]       r_out_gear;

    // Handshake decode.
    logic        in_acc;
    logic        out_acc;
    logic [31:0] since_last;
    logic        load_out;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign since_last  = i_now_us - r_last_time;
    assign load_out    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_speed     = r_out_speed;
    assign o_gear_number = r_out_gear;

    // Shared multiplier and its operand selection.
    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [47:0] mul_p;

    always_comb begin
        unique case (r_state)
            S_MUL: begin
                mul_a = r_period;
                mul_b = r_ppm;
            end
            S_WANT: begin
                mul_a = {16'd0, r_speed};
                mul_b = r_ratio[r_g];
            end
            S_TOL: begin
                mul_a = r_want;
                mul_b = {9'd0, r_tol};
            end
            S_HUND: begin
                mul_a = r_diff;
                mul_b = {9'd0, PCT_SCALE};
            end
            default: begin
                mul_a = r_period;
                mul_b = r_ppm;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One restoring divide step.
    logic [DIV_W:0]   rem_sh;
    logic             div_ge;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W-1:0] n_quo;
    logic [15:0]      n_speed;

    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign div_ge = {{(48 - DIV_W - 1){1'b0}}, rem_sh} >= r_den;
    always_comb begin
        n_rem = div_ge ? DIV_W'(rem_sh - r_den[DIV_W:0]) : rem_sh[DIV_W-1:0];
    end
    assign n_quo   = {r_quo[DIV_W-2:0], div_ge};
    assign n_speed = (|n_quo[DIV_W-1:16]) ? SPEED_MAX : n_quo[15:0];

    // Gear decision helpers; the hit compares the scaled error from the multiplier
    // in the current cycle against the tolerance product of the cycle before.
    logic [31:0] have;
    logic        gear_skip;
    logic        gear_hit;

    assign have      = {12'd0, r_rpm, 4'd0};
    assign gear_skip = r_clutch || (r_speed < LOW_SPEED_LIMIT) || (r_rpm < LOW_RPM_LIMIT);
    assign gear_hit  = (mul_p[38:0] <= r_tolw);

    // Sequencer, pulse state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_last_time <= 32'd0;
            r_period    <= 32'd0;
            r_fresh     <= 1'b0;
            r_ppm       <= PPM_RESET;
            r_tol       <= TOL_RESET;
            r_ratio     <= GEAR_RESET;
            r_cnt       <= 5'd0;
            r_g         <= 3'd0;
        end else begin
            // Configuration writes.
            if (i_cfg_we) begin
                if (i_cfg_index == REG_PPM) begin
                    r_ppm <= i_cfg_wdata;
                end
                if (i_cfg_index == REG_TOL) begin
                    r_tol <= i_cfg_wdata[6:0];
                end
                for (int g = 0; g < GEAR_SLOTS; g++) begin
                    if (i_cfg_index == 3'(REG_GEAR1 + 3'(g))) begin
                        r_ratio[g] <= i_cfg_wdata;
                    end
                end
            end

            // Result register.
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_operation == OP_PULSE) begin
                            if (since_last >= MIN_GAP_US) begin
                                r_period    <= since_last;
                                r_last_time <= i_now_us;
                                r_fresh     <= 1'b1;
                            end
                        end else begin
                            r_fresh <= 1'b0;
                            if (r_fresh && (since_last <= TIMEOUT_US)) begin
                                r_state <= S_MUL;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_cnt   <= 5'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == DIV_LAST) begin
                        r_state <= S_GSEL;
                    end
                end
                S_GSEL: begin
                    r_g     <= 3'd0;
                    r_state <= gear_skip ? S_DONE : S_WANT;
                end
                S_WANT: begin
                    r_state <= S_TOL;
                end
                S_TOL: begin
                    r_state <= S_HUND;
                end
                S_HUND: begin
                    r_state <= S_DONE;
                    if (!gear_hit && (r_g != GEAR_LAST)) begin
                        r_g     <= r_g + 3'd1;
                        r_state <= S_WANT;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers; these carry no reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_rpm    <= i_engine_rpm;
                r_clutch <= i_clutch_pressed;
                r_speed  <= 16'd0;
                r_gear   <= 3'd0;
                r_rem    <= '0;
                r_quo    <= SPEED_SCALE;
            end
            S_MUL: begin
                r_den <= mul_p;
            end
            S_DIV: begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_cnt == DIV_LAST) begin
                    r_speed <= n_speed;
                end
            end
            S_GSEL: begin
                r_gear <= 3'd0;
            end
            S_WANT: begin
                r_want <= mul_p[31:0];
            end
            S_TOL: begin
                r_tolw <= mul_p[38:0];
                r_diff <= (have > r_want) ? (have - r_want) : (r_want - have);
            end
            S_HUND: begin
                // The first gear within tolerance ends the search.
                if (gear_hit) begin
                    r_gear <= r_g + 3'd1;
                end
            end
            S_DONE: begin
                r_gear <= r_gear;
            end
            default: begin
                r_gear <= r_gear;
            end
        endcase
        if (load_out) begin
            r_out_speed <= r_speed;
            r_out_gear  <= r_gear;
        end
    end

    // Checks on the sequencer and the pulse state.
    property p_fresh_set;
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_PULSE) && (since_last >= MIN_GAP_US)) |=> r_fresh;
    endproperty
    a_fresh_set: assert property (p_fresh_set) else $error("fresh flag not set by pulse");

    property p_fresh_clr;
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_operation == OP_EVAL)) |=> !r_fresh;
    endproperty
    a_fresh_clr: assert property (p_fresh_clr) else $error("fresh flag not cleared");

    property p_gear_range;
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_gear_number <= 3'(GEARS_USED));
    endproperty
    a_gear_range: assert property (p_gear_range) else $error("gear out of range");

    property p_gear_speed;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_gear_number != 3'd0)) |-> (o_speed >= LOW_SPEED_LIMIT);
    endproperty
    a_gear_speed: assert property (p_gear_speed) else $error("gear given at low speed");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the wheel speed and gear detector.
`timescale 1ns / 1ps

module testbench;
    import wsgd_pkg::*;

    localparam int IDLE_PCT      = 12;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_WORDS   = 190;

    // One input word and one speed and gear reading.
    typedef struct packed {
        logic        op;
        logic [31:0] now_us;
        logic [15:0] rpm;
        logic        clutch;
    } t_word;

    typedef struct packed {
        logic [15:0] speed;
        logic [2:0]  gear;
    } t_reading;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        in_operation = OP_PULSE;
    logic [31:0] in_now_us = '0;
    logic [15:0] in_rpm = '0;
    logic        in_clutch = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] out_speed;
    logic [2:0]  out_gear;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // Words waiting to be sent and readings waiting to arrive.
    t_word      pending_q[$];
    t_reading   due_readings[$];
    t_word      cur_word;
    int         words_queued = 0;
    int         words_taken = 0;
    int         cycles = 0;
    int         errors = 0;
    logic       calm = 1'b0;

    // Predicted register contents and measurement state.
    logic [15:0] ppm_cfg;
    logic [6:0]  tol_cfg;
    t_ratio_tab  ratio_cfg;
    t_ratio_tab  plan_ratio;
    logic [31:0] last_edge_us;
    logic [31:0] held_period;
    logic        fresh;

    // Generator's own view of the wheel, used to aim stimulus.
    logic [31:0] gen_stamp = '0;
    logic [31:0] gen_last = '0;
    logic [31:0] gen_period = '0;
    int          useful = 0;

    // Figures for the closing summary.
    int pulses_in = 0;
    int edges_kept = 0;
    int evals_in = 0;
    int geared = 0;
    int saturated = 0;
    int settings = 1;

    wheel_speed_and_gear_detector dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_operation      (in_operation),
        .i_now_us         (in_now_us),
        .i_engine_rpm     (in_rpm),
        .i_clutch_pressed (in_clutch),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_speed          (out_speed),
        .o_gear_number    (out_gear),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_wdata      (cfg_wdata)
    );

    // Clock with a 20 ns period.
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Speed in whole mph from a pulse period, saturated.
    function automatic logic [15:0] speed_of(input logic [31:0] period);
        logic [63:0] den;
        logic [63:0] quot;
        den = 64'(period) * 64'(ppm_cfg);
        if (den == 64'd0)
            return SPEED_MAX;
        quot = 64'(SPEED_SCALE) / den;
        return (quot > 64'(SPEED_MAX)) ? SPEED_MAX : quot[15:0];
    endfunction

    // First gear whose rpm per mph lies within the tolerance.
    function automatic logic [2:0] gear_of(input logic [15:0] spd, input logic [15:0] rpm,
                                           input logic clutch);
        logic [63:0] want;
        logic [63:0] have;
        logic [63:0] diff;
        if (clutch || spd < LOW_SPEED_LIMIT || rpm < LOW_RPM_LIMIT)
            return 3'd0;
        for (int g = 0; g < GEARS_USED; g++) begin
            want = 64'(spd) * 64'(ratio_cfg[g]);
            have = 64'(rpm) * 64'd16;
            diff = (have > want) ? have - want : want - have;
            if (diff * 64'(PCT_SCALE) <= 64'(tol_cfg) * want)
                return 3'(g + 1);
        end
        return 3'd0;
    endfunction

    // Apply one accepted word to the predicted state and note any reading it causes.
    function automatic void absorb_word(input t_word w);
        logic [31:0] elapsed;
        logic        was_fresh;
        t_reading    r;
        elapsed = w.now_us - last_edge_us;
        if (w.op == OP_PULSE) begin
            pulses_in++;
            if (elapsed >= MIN_GAP_US) begin
                held_period = elapsed;
                last_edge_us = w.now_us;
                fresh = 1'b1;
                edges_kept++;
            end
        end else begin
            evals_in++;
            was_fresh = fresh;
            fresh = 1'b0;
            r.speed = 16'd0;
            if (was_fresh && elapsed <= TIMEOUT_US)
                r.speed = speed_of(held_period);
            r.gear = gear_of(r.speed, w.rpm, w.clutch);
            if (r.gear != 3'd0)
                geared++;
            if (r.speed == SPEED_MAX)
                saturated++;
            due_readings.push_back(r);
        end
    endfunction

    // Driver: presents queued words and predicts each one as it is taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                absorb_word(cur_word);
                words_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    cur_word = pending_q.pop_front();
                    in_valid <= 1'b1;
                    in_operation <= cur_word.op;
                    in_now_us <= cur_word.now_us;
                    in_rpm <= cur_word.rpm;
                    in_clutch <= cur_word.clutch;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each reading against the oldest prediction.
    always @(posedge clk) begin
        t_reading r;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (due_readings.size() == 0) begin
                    $error("reading with no evaluation pending: speed %0d gear %0d",
                           out_speed, out_gear);
                    errors++;
                end else begin
                    r = due_readings.pop_front();
                    if (out_speed !== r.speed) begin
                        $error("speed: expected %0d, got %0d", r.speed, out_speed);
                        errors++;
                    end
                    if (out_gear !== r.gear) begin
                        $error("gear_number: expected %0d, got %0d", r.gear, out_gear);
                        errors++;
                    end
                end
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Cycle limit in case the block hangs.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Queue one word and keep the generator's view of the wheel in step.
    task automatic push_word(input logic op, input logic [31:0] at_us,
                             input logic [15:0] rpm, input logic clutch);
        t_word w;
        w.op = op;
        w.now_us = at_us;
        w.rpm = rpm;
        w.clutch = clutch;
        pending_q.push_back(w);
        words_queued++;
        gen_stamp = at_us;
        if (op == OP_EVAL) begin
            useful++;
        end else if ((at_us - gen_last) >= MIN_GAP_US) begin
            gen_period = at_us - gen_last;
            gen_last = at_us;
            useful++;
        end
    endtask

    // A plausible drive: steady pulses, then an evaluation aimed near one gear.
    task automatic queue_drive_run();
        logic [31:0] period;
        logic [31:0] gap;
        logic [63:0] rpm_want;
        logic [15:0] spd;
        logic [15:0] ratio;
        int          reps;
        int          slack;
        if (ppm_cfg == 16'd0)
            period = $urandom_range(200, 20000);
        else
            period = 32'(64'(SPEED_SCALE) / (64'($urandom_range(1, 180)) * 64'(ppm_cfg)));
        if (period < MIN_GAP_US)
            period = MIN_GAP_US + $urandom_range(0, 50);
        reps = $urandom_range(1, 3);
        repeat (reps) begin
            // Occasional contact bounce shortly after an edge.
            if ($urandom_range(9) == 0)
                push_word(OP_PULSE, gen_stamp + $urandom_range(0, 199),
                          16'($urandom), 1'($urandom));
            gap = period + $urandom_range(0, period / 64);
            push_word(OP_PULSE, gen_stamp + gap, 16'($urandom), 1'($urandom));
        end
        spd = speed_of(gen_period);
        case ($urandom_range(9))
            0: gap = TIMEOUT_US + $urandom_range(1, 5000);
            1: gap = TIMEOUT_US;
            default: gap = $urandom_range(0, gen_period);
        endcase
        ratio = ratio_cfg[$urandom_range(0, GEARS_USED - 1)];
        slack = $urandom_range(0, tol_cfg + 4);
        rpm_want = (64'(spd) * 64'(ratio)) / 64'd16;
        if ($urandom_range(1) == 1)
            rpm_want = rpm_want * (100 + slack) / 100;
        else
            rpm_want = rpm_want * (100 - ((slack > 100) ? 100 : slack)) / 100;
        if (rpm_want > 64'd65535)
            rpm_want = 64'd65535;
        push_word(OP_EVAL, gen_stamp + gap, rpm_want[15:0], ($urandom_range(7) == 0));
    endtask

    // A word of any kind with an awkward spacing and random content.
    task automatic queue_noise();
        logic [31:0] gap;
        case ($urandom_range(5))
            0: gap = $urandom_range(0, 199);
            1: gap = MIN_GAP_US;
            2: gap = $urandom;
            3: gap = TIMEOUT_US + $urandom_range(0, 1);
            default: gap = $urandom_range(200, 40000);
        endcase
        push_word(1'($urandom_range(1)), gen_stamp + gap, 16'($urandom), 1'($urandom));
    endtask

    task automatic feed(input int count);
        int start;
        start = useful;
        while (useful - start < count) begin
            if ($urandom_range(99) < 80)
                queue_drive_run();
            else
                queue_noise();
        end
    endtask

    // Wait until every queued word is taken and every reading has come back.
    task automatic wait_drained();
        while (words_taken != words_queued || due_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int count);
        feed(count / 2);
        wait_drained();
        feed(count - count / 2);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PPM: ppm_cfg = val;
            REG_TOL: tol_cfg = val[6:0];
            default: ratio_cfg[idx - REG_GEAR1] = val;
        endcase
    endtask

    // Let the block go quiet, then load every register.
    task automatic configure(input logic [15:0] ppm, input logic [6:0] tol);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_PPM, ppm);
        write_reg(REG_TOL, 16'(tol));
        for (int g = 0; g < GEAR_SLOTS; g++)
            write_reg(REG_GEAR1 + 3'(g), plan_ratio[g]);
        settings++;
    endtask

    task automatic plan_random_ratios();
        int ratio;
        ratio = $urandom_range(2500, 6000);
        for (int g = 0; g < GEAR_SLOTS; g++) begin
            plan_ratio[g] = ($urandom_range(9) == 0) ? 16'd0 : 16'(ratio);
            ratio = ratio * $urandom_range(60, 95) / 100;
        end
    endtask

    // Stimulus and phase sequencing.
    initial begin
        ppm_cfg = PPM_RESET;
        tol_cfg = TOL_RESET;
        ratio_cfg = GEAR_RESET;
        last_edge_us = '0;
        held_period = '0;
        fresh = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at reset settings: stale reads, bounce, speed limits,
        // timeout boundary and timestamp wrap.
        push_word(OP_EVAL, 32'd0, 16'hFFFF, 1'b0);
        push_word(OP_PULSE, 32'd0, 16'd0, 1'b0);
        push_word(OP_PULSE, 32'd199, 16'd0, 1'b0);
        push_word(OP_PULSE, 32'd200, 16'd0, 1'b0);
        push_word(OP_EVAL, 32'd200, 16'hFFFF, 1'b0);
        push_word(OP_EVAL, 32'd201, 16'd6024, 1'b0);
        push_word(OP_PULSE, 32'd20220, 16'd0, 1'b0);
        push_word(OP_EVAL, 32'd20220, 16'd800, 1'b0);
        push_word(OP_PULSE, 32'd50250, 16'd0, 1'b0);
        push_word(OP_EVAL, 32'd50250, 16'd5000, 1'b0);
        push_word(OP_PULSE, 32'd52252, 16'd0, 1'b0);
        push_word(OP_EVAL, 32'd52252, 16'd6024, 1'b1);
        push_word(OP_PULSE, 32'd54254, 16'd0, 1'b0);
        push_word(OP_EVAL, 32'd54254, 16'd6024, 1'b0);
        push_word(OP_PULSE, 32'd56256, 16'd0, 1'b0);
        push_word(OP_EVAL, 32'd56256, 16'd799, 1'b0);
        push_word(OP_PULSE, 32'd58258, 16'd0, 1'b0);
        push_word(OP_EVAL, 32'd158258, 16'd6024, 1'b0);
        push_word(OP_PULSE, 32'd160260, 16'd0, 1'b0);
        push_word(OP_EVAL, 32'd260261, 16'd6024, 1'b0);
        push_word(OP_PULSE, 32'hFFFFFF00, 16'hFFFF, 1'b1);
        push_word(OP_PULSE, 32'h000006D2, 16'd0, 1'b0);
        push_word(OP_EVAL, 32'h000006D2, 16'd4376, 1'b0);
        push_word(OP_PULSE, 32'hFFFFFFFF, 16'd0, 1'b0);
        push_word(OP_EVAL, 32'hFFFFFFFF, 16'hFFFF, 1'b1);

        // Extremes: smallest pulse constant, widest tolerance, zero and full ratios.
        plan_ratio = '{16'hFFFF, 16'd0, 16'd1, 16'd32768, 16'd3213, 16'd0};
        configure(16'd1, 7'd100);
        run_phase(PHASE_WORDS);

        // Largest pulse constant with an exact-match tolerance.
        for (int g = 0; g < GEAR_SLOTS; g++)
            plan_ratio[g] = 16'($urandom);
        configure(16'hFFFF, 7'd0);
        run_phase(PHASE_WORDS);

        // Zero pulse constant, so every fresh reading saturates.
        for (int g = 0; g < GEAR_SLOTS; g++)
            plan_ratio[g] = 16'($urandom);
        configure(16'd0, 7'($urandom_range(0, 100)));
        run_phase(PHASE_WORDS);

        // Reset values written back, with both sides running flat out.
        plan_ratio = GEAR_RESET;
        configure(PPM_RESET, TOL_RESET);
        calm = 1'b1;
        run_phase(PHASE_WORDS);
        wait_drained();
        calm = 1'b0;

        // Realistic random gearboxes.
        repeat (4) begin
            plan_random_ratios();
            configure(16'($urandom_range(200, 8000)), 7'($urandom_range(0, 100)));
            run_phase(PHASE_WORDS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_readings.size() != 0) begin
            $error("%0d expected readings never arrived", due_readings.size());
            errors++;
        end

        $display("Covered %0d pulse words (%0d kept as edges) and %0d evaluations",
                 pulses_in, edges_kept, evals_in);
        $display("over %0d register settings; %0d readings named a gear, %0d saturated.",
                 settings, geared, saturated);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### wheel_speed_and_gear_detector.f
sv/wsgd_pkg.sv
sv/wheel_speed_and_gear_detector.sv
tb/sv/testbench.sv
